>>> hdl/vppa_pkg.sv
`timescale 1ns / 1ps
// vppa_pkg: shared types and constants of the voice pool priority allocator
// used by voice_pool_priority_allocator, vppa_checker and the bench; depends on nothing

package vppa_pkg;

    // command codes carried in the input word
    typedef enum logic [3:0] {
        CMD_ACQUIRE    = 4'd0,
        CMD_STOP       = 4'd1,
        CMD_PAUSE      = 4'd2,
        CMD_RESUME     = 4'd3,
        CMD_QUERY      = 4'd4,
        CMD_STOP_ALL   = 4'd5,
        CMD_PAUSE_ALL  = 4'd6,
        CMD_RESUME_ALL = 4'd7,
        CMD_SWEEP      = 4'd8
    } cmd_t;

    // per-voice playback state
    typedef enum logic [1:0] {
        VS_FREE     = 2'd0,
        VS_PLAYING  = 2'd1,
        VS_PAUSED   = 2'd2,
        VS_FINISHED = 2'd3
    } voice_state_t;

    // controller states
    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_SCAN   = 2'd1,
        FSM_FINISH = 2'd2
    } fsm_state_t;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [7:0]  PRIO_RESET    = 8'd128;
    localparam logic [5:0]  COUNT_MAX     = 6'd63;
    localparam logic [5:0]  ENABLED_RESET = 6'd32;
    localparam logic [31:0] ID_FIRST      = 32'd1;
    localparam logic [31:0] ID_LAST       = 32'hFFFF_FFFF;
    localparam int          SLOT_W        = 5;

    // one pool entry as kept in the slot memory
    typedef struct packed {
        voice_state_t vstate;
        logic [31:0]  id;
        logic [7:0]   prio;
    } slot_entry_t;

    localparam slot_entry_t SLOT_RESET = '{vstate: VS_FREE, id: 32'd0, prio: PRIO_RESET};

    // input word, last field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] voice_handle;
        logic [7:0]  priority_req;
        logic [3:0]  command;
    } in_word_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [5:0]        active_voices;
        logic [1:0]        voice_state_out;
        logic [31:0]       evicted_id;
        logic              stolen;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       granted_id;
        logic [1:0]        status;
    } result_t;

endpackage

>>> hdl/voice_pool_priority_allocator.sv
`timescale 1ns / 1ps
// voice_pool_priority_allocator: voice pool with first-free acquire and priority stealing
// uses vppa_pkg; the slot table lives in one synchronous memory inside this module
//
// Usage
//   s_tdata carries one command word (acquire, stop, pause, resume, query, bulk
//   stop/pause/resume, sweep); m_tdata returns exactly one result word per command.
//   cfg_we/cfg_wdata set the number of enabled slots; write only while idle.
// Command sequence
//   one command at a time: the n enabled slots, n = min(enabled_voices, POOL_SIZE), are
//   read one per cycle through the single registered read port, then written back
//   and the result registered. s_tready rises with m_tvalid, so the next word is
//   taken only after the last result is registered.
// Reset
//   aresetn low clears the controller, the output register, the id counter (1),
//   the active count (0) and the per-slot valid bits; a slot not yet written
//   reads as free, id 0, priority 128. No clearing pass is needed.
// Stalls
//   a result waits in the output register while m_tready is low; the controller
//   holds its finished command until the register frees and takes no new word.

module voice_pool_priority_allocator
    import vppa_pkg::*;
#(
    parameter int POOL_SIZE = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // enabled slot count register
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    // command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command[3:0], priority_req[11:4], voice_handle[43:12]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // status[1:0], granted_id[33:2], slot[38:34],
                                   // stolen[39], evicted_id[71:40],
                                   // voice_state_out[73:72], active_voices[79:74]
);

    localparam int IdxW = $clog2(POOL_SIZE);
    localparam int CntW = $clog2(POOL_SIZE + 1);
    localparam int LimW = (CntW > 6) ? CntW : 6;

    // slot memory and per-entry valid bits
    slot_entry_t            slot_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0]   valid_reg;

    fsm_state_t             state_reg, state_next;
    logic [5:0]             enabled_reg;
    cmd_t                   cmd_reg;
    logic [7:0]             prio_req_reg;
    logic [31:0]            handle_reg;

    logic [LimW-1:0]        issue_cnt_reg;
    logic                   rd_pend_reg;
    logic                   rd_vld_reg;
    logic [IdxW-1:0]        proc_idx_reg;
    slot_entry_t            rd_data_reg;

    logic                   free_found_reg;
    logic [IdxW-1:0]        free_idx_reg;
    logic                   steal_found_reg;
    logic [IdxW-1:0]        steal_idx_reg;
    logic [7:0]             steal_prio_reg;
    logic [31:0]            steal_id_reg;
    logic                   match_found_reg;
    logic [IdxW-1:0]        match_idx_reg;
    slot_entry_t            match_entry_reg;

    logic [31:0]            next_id_reg;
    logic [5:0]             active_cnt_reg;

    logic                   m_tvalid_reg;
    result_t                m_data_reg;

    logic [LimW-1:0]        limit;
    logic                   accept;
    logic                   issue;
    logic [IdxW-1:0]        rd_addr;
    logic                   scan_done;
    logic                   advance;
    slot_entry_t            cur;
    in_word_t               in_word;

    logic                   bulk_we;
    slot_entry_t            bulk_entry;
    logic                   sweep_dec;

    logic                   fin_we;
    logic [IdxW-1:0]        fin_idx;
    slot_entry_t            fin_entry;
    logic                   fin_take_id;
    logic                   fin_inc;
    result_t                fin_res;
    logic [LimW-1:0]        fin_idx_wide;
    voice_state_t           new_state;

    logic                   wr_we;
    logic [IdxW-1:0]        wr_addr;
    slot_entry_t            wr_data;

    // effective number of enabled slots
    assign limit = (LimW'(enabled_reg) < LimW'(POOL_SIZE)) ? LimW'(enabled_reg)
                                                            : LimW'(POOL_SIZE);

    assign in_word   = in_word_t'(s_tdata);
    assign accept    = s_tvalid && s_tready;
    assign issue     = (state_reg == FSM_SCAN) && (issue_cnt_reg < limit);
    assign rd_addr   = issue_cnt_reg[IdxW-1:0];
    assign scan_done = (state_reg == FSM_SCAN) && !issue && !rd_pend_reg;
    assign advance   = (state_reg == FSM_FINISH) && (!m_tvalid_reg || m_tready);
    assign cur       = rd_vld_reg ? rd_data_reg : SLOT_RESET;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                if (scan_done) begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH: begin
                if (advance) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        s_tready = (state_reg == FSM_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= ENABLED_RESET;
        end else if (cfg_we) begin
            enabled_reg <= cfg_wdata;
        end
    end

    // command capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= cmd_t'(in_word.command);
            prio_req_reg <= in_word.priority_req;
            handle_reg   <= in_word.voice_handle;
        end
    end

    // read issue counter and read pipeline flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= issue;
            if (accept) begin
                issue_cnt_reg <= '0;
            end else if (issue) begin
                issue_cnt_reg <= issue_cnt_reg + LimW'(1);
            end
        end
    end

    // slot memory read port
    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg  <= slot_mem[rd_addr];
            rd_vld_reg   <= valid_reg[rd_addr];
            proc_idx_reg <= rd_addr;
        end
    end

    // bulk commands rewrite each affected entry as it comes back from memory
    always_comb begin
        bulk_we    = 1'b0;
        bulk_entry = cur;
        sweep_dec  = 1'b0;
        if (rd_pend_reg) begin
            unique case (cmd_reg)
                CMD_STOP_ALL: begin
                    if (cur.vstate != VS_FREE) begin
                        bulk_entry.vstate = VS_FINISHED;
                        bulk_we = 1'b1;
                    end
                end
                CMD_PAUSE_ALL: begin
                    if (cur.vstate == VS_PLAYING) begin
                        bulk_entry.vstate = VS_PAUSED;
                        bulk_we = 1'b1;
                    end
                end
                CMD_RESUME_ALL: begin
                    if (cur.vstate == VS_PAUSED) begin
                        bulk_entry.vstate = VS_PLAYING;
                        bulk_we = 1'b1;
                    end
                end
                CMD_SWEEP: begin
                    if (cur.vstate == VS_FINISHED) begin
                        bulk_entry.vstate = VS_FREE;
                        bulk_entry.id     = 32'd0;
                        bulk_we   = 1'b1;
                        sweep_dec = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // scan trackers: first free slot, cheapest stealable slot, first id match
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_found_reg  <= 1'b0;
            steal_found_reg <= 1'b0;
            match_found_reg <= 1'b0;
        end else if (accept) begin
            free_found_reg  <= 1'b0;
            steal_found_reg <= 1'b0;
            match_found_reg <= 1'b0;
        end else if (rd_pend_reg) begin
            if (!free_found_reg && (cur.vstate == VS_FREE)) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= proc_idx_reg;
            end
            if ((cur.prio <= prio_req_reg) &&
                (!steal_found_reg || (cur.prio < steal_prio_reg))) begin
                steal_found_reg <= 1'b1;
                steal_idx_reg   <= proc_idx_reg;
                steal_prio_reg  <= cur.prio;
                steal_id_reg    <= cur.id;
            end
            if (!match_found_reg && (handle_reg != 32'd0) && (cur.id == handle_reg) &&
                (cur.vstate != VS_FREE)) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= proc_idx_reg;
                match_entry_reg <= cur;
            end
        end
    end

    // finishing step: write-back and result word
    always_comb begin
        fin_we      = 1'b0;
        fin_idx     = '0;
        fin_entry   = SLOT_RESET;
        fin_take_id = 1'b0;
        fin_inc     = 1'b0;
        new_state   = VS_FREE;
        fin_res     = '0;
        unique case (cmd_reg)
            CMD_ACQUIRE: begin
                if (free_found_reg || steal_found_reg) begin
                    fin_idx          = free_found_reg ? free_idx_reg : steal_idx_reg;
                    fin_we           = 1'b1;
                    fin_entry.vstate = VS_PLAYING;
                    fin_entry.id     = next_id_reg;
                    fin_entry.prio   = prio_req_reg;
                    fin_take_id      = 1'b1;
                    fin_inc          = free_found_reg;
                    fin_res.status          = STATUS_OK;
                    fin_res.granted_id      = next_id_reg;
                    fin_res.stolen          = !free_found_reg;
                    fin_res.evicted_id      = free_found_reg ? 32'd0 : steal_id_reg;
                    fin_res.voice_state_out = VS_PLAYING;
                end else begin
                    fin_res.status = STATUS_FULL;
                end
            end
            CMD_STOP, CMD_PAUSE, CMD_RESUME, CMD_QUERY: begin
                if (match_found_reg) begin
                    new_state = match_entry_reg.vstate;
                    if (cmd_reg == CMD_STOP) begin
                        new_state = VS_FINISHED;
                    end else if ((cmd_reg == CMD_PAUSE) &&
                                 (match_entry_reg.vstate == VS_PLAYING)) begin
                        new_state = VS_PAUSED;
                    end else if ((cmd_reg == CMD_RESUME) &&
                                 (match_entry_reg.vstate == VS_PAUSED)) begin
                        new_state = VS_PLAYING;
                    end
                    fin_idx          = match_idx_reg;
                    fin_we           = 1'b1;
                    fin_entry        = match_entry_reg;
                    fin_entry.vstate = new_state;
                    fin_res.status          = STATUS_OK;
                    fin_res.granted_id      = match_entry_reg.id;
                    fin_res.voice_state_out = new_state;
                end else begin
                    fin_res.status = STATUS_NOT_FOUND;
                end
            end
            default: begin
                fin_res.status = STATUS_OK;
            end
        endcase
        fin_res.slot = fin_idx_wide[SLOT_W-1:0];
        if (fin_inc && (active_cnt_reg != COUNT_MAX)) begin
            fin_res.active_voices = active_cnt_reg + 6'd1;
        end else begin
            fin_res.active_voices = active_cnt_reg;
        end
    end

    assign fin_idx_wide = LimW'(fin_idx);

    // single write port shared by the scan and the finishing step
    assign wr_we   = bulk_we || (fin_we && advance);
    assign wr_addr = (state_reg == FSM_SCAN) ? proc_idx_reg : fin_idx;
    assign wr_data = (state_reg == FSM_SCAN) ? bulk_entry : fin_entry;

    always_ff @(posedge aclk) begin
        if (wr_we) begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_we) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // id counter, wraps past zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_id_reg <= ID_FIRST;
        end else if (advance && fin_take_id) begin
            next_id_reg <= (next_id_reg == ID_LAST) ? ID_FIRST : next_id_reg + 32'd1;
        end
    end

    // active voice count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_cnt_reg <= '0;
        end else if (sweep_dec) begin
            if (active_cnt_reg != 6'd0) begin
                active_cnt_reg <= active_cnt_reg - 6'd1;
            end
        end else if (advance) begin
            active_cnt_reg <= fin_res.active_voices;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= fin_res;
        end
    end

endmodule

>>> hdl/vppa_checker.sv
`timescale 1ns / 1ps
// vppa_checker: port-level checks of voice_pool_priority_allocator over time
// uses vppa_pkg; bound to the top level at the end of this file

module vppa_checker
    import vppa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // no result word survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one command in flight: no second word the cycle after acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while another is in progress");

    // a steal is always a successful acquire of a playing voice
    a_steal_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[39] |-> (m_tdata[1:0] == STATUS_OK) &&
            (m_tdata[73:72] == VS_PLAYING))
        else $error("stolen flag on a failed or non-acquire result");

    // failure results carry no id, slot or eviction
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != STATUS_OK) |->
            (m_tdata[73:2] == 72'd0))
        else $error("failure result carries payload");

endmodule

bind voice_pool_priority_allocator vppa_checker u_vppa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/voice_pool_priority_allocator_tb.sv
`timescale 1ns / 1ps
// voice_pool_priority_allocator_tb: self-checking bench for the voice pool allocator
// depends on vppa_pkg and voice_pool_priority_allocator; drives command words,
// predicts every result word and compares it field by field

module voice_pool_priority_allocator_tb;
    import vppa_pkg::*;

    localparam int POOL_SLOTS     = 32;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 50;
    localparam int PHASES         = 9;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [5:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // command[3:0], priority_req[11:4], voice_handle[43:12]
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // status[1:0], granted_id[33:2], slot[38:34], stolen[39],
                            // evicted_id[71:40], voice_state_out[73:72], active_voices[79:74]

    voice_pool_priority_allocator #(
        .POOL_SIZE(POOL_SLOTS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // one directed row: a register write or a command word
    typedef struct {
        bit          is_cfg;
        logic [5:0]  cfg_val;
        in_word_t    word;
        bit          has_exp;
        result_t     exp;
    } stim_row_t;

    // shadow copy of the pool
    voice_state_t vs_model [POOL_SLOTS];
    logic [31:0]  id_model [POOL_SLOTS];
    logic [7:0]   prio_model [POOL_SLOTS];
    logic [31:0]  next_id_model;
    logic [5:0]   active_model;
    logic [5:0]   en_model;

    result_t   due_results[$];
    stim_row_t directed_rows[$];

    // typed expectation travelling with the word on the input channel
    bit      row_has_exp;
    result_t row_exp;

    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    int errors;
    int n_items, n_results, n_steals, n_full, n_missed, n_cfg;

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // next pool state and result word for one command
    function automatic result_t pool_result(input logic [3:0] cmd, input logic [7:0] prio,
                                            input logic [31:0] handle);
        result_t r;
        int      n;
        int      pick;
        r    = '0;
        n    = (int'(en_model) > POOL_SLOTS) ? POOL_SLOTS : int'(en_model);
        pick = -1;
        case (cmd)
            CMD_ACQUIRE: begin
                for (int i = 0; i < n; i++)
                    if (pick < 0 && vs_model[i] == VS_FREE)
                        pick = i;
                if (pick >= 0) begin
                    if (active_model < COUNT_MAX)
                        active_model = active_model + 6'd1;
                end else begin
                    // steal the lowest priority not above the request, first index on a tie
                    for (int i = 0; i < n; i++)
                        if (prio_model[i] <= prio && (pick < 0 || prio_model[i] < prio_model[pick]))
                            pick = i;
                    if (pick >= 0) begin
                        r.stolen     = 1'b1;
                        r.evicted_id = id_model[pick];
                    end
                end
                if (pick >= 0) begin
                    r.granted_id  = next_id_model;
                    next_id_model = next_id_model + 32'd1;
                    if (next_id_model == 32'd0)
                        next_id_model = ID_FIRST;
                    id_model[pick]    = r.granted_id;
                    prio_model[pick]  = prio;
                    vs_model[pick]    = VS_PLAYING;
                    r.slot            = 5'(pick);
                    r.voice_state_out = VS_PLAYING;
                end else begin
                    r.status = STATUS_FULL;
                end
            end
            CMD_STOP, CMD_PAUSE, CMD_RESUME, CMD_QUERY: begin
                if (handle != 32'd0)
                    for (int i = 0; i < n; i++)
                        if (pick < 0 && id_model[i] == handle && vs_model[i] != VS_FREE)
                            pick = i;
                if (pick < 0) begin
                    r.status = STATUS_NOT_FOUND;
                end else begin
                    if (cmd == CMD_STOP)
                        vs_model[pick] = VS_FINISHED;
                    else if (cmd == CMD_PAUSE && vs_model[pick] == VS_PLAYING)
                        vs_model[pick] = VS_PAUSED;
                    else if (cmd == CMD_RESUME && vs_model[pick] == VS_PAUSED)
                        vs_model[pick] = VS_PLAYING;
                    r.granted_id      = id_model[pick];
                    r.slot            = 5'(pick);
                    r.voice_state_out = vs_model[pick];
                end
            end
            CMD_STOP_ALL, CMD_PAUSE_ALL, CMD_RESUME_ALL, CMD_SWEEP: begin
                for (int i = 0; i < n; i++) begin
                    if (cmd == CMD_STOP_ALL) begin
                        if (vs_model[i] != VS_FREE)
                            vs_model[i] = VS_FINISHED;
                    end else if (cmd == CMD_PAUSE_ALL) begin
                        if (vs_model[i] == VS_PLAYING)
                            vs_model[i] = VS_PAUSED;
                    end else if (cmd == CMD_RESUME_ALL) begin
                        if (vs_model[i] == VS_PAUSED)
                            vs_model[i] = VS_PLAYING;
                    end else if (vs_model[i] == VS_FINISHED) begin
                        vs_model[i] = VS_FREE;
                        id_model[i] = 32'd0;
                        if (active_model > 6'd0)
                            active_model = active_model - 6'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.active_voices = active_model;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (a !== e) begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
            errors++;
        end
    endtask

    task automatic check_result(input result_t e, input result_t a);
        check_field("status", 32'(e.status), 32'(a.status));
        check_field("granted_id", e.granted_id, a.granted_id);
        check_field("slot", 32'(e.slot), 32'(a.slot));
        check_field("stolen", 32'(e.stolen), 32'(a.stolen));
        check_field("evicted_id", e.evicted_id, a.evicted_id);
        check_field("voice_state_out", 32'(e.voice_state_out), 32'(a.voice_state_out));
        check_field("active_voices", 32'(e.active_voices), 32'(a.active_voices));
        n_results++;
        if (e.stolen)
            n_steals++;
        if (e.status == STATUS_FULL)
            n_full++;
        if (e.status == STATUS_NOT_FOUND)
            n_missed++;
    endtask

    // predict on every accepted command word, check every accepted result word
    always @(posedge aclk) begin : monitor
        in_word_t w;
        result_t  r;
        if (aresetn) begin
            if (cfg_we) begin
                en_model = cfg_wdata;
                n_cfg++;
            end
            if (s_tvalid && s_tready) begin
                w = in_word_t'(s_tdata);
                r = pool_result(w.command, w.priority_req, w.voice_handle);
                if (row_has_exp)
                    due_results.push_back(row_exp);
                else
                    due_results.push_back(r);
                n_items++;
            end
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: result word with nothing expected, got %0h", $time, m_tdata);
                    errors++;
                end else begin
                    check_result(due_results.pop_front(), result_t'(m_tdata));
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // present one word, hold it until accepted
    task automatic send_word(input in_word_t w, input bit has_exp, input result_t e);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= w;
        row_has_exp <= has_exp;
        row_exp     <= e;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold off the sender until every result is back and the block is idle
    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_enabled(input logic [5:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // directed table builders
    function automatic void add_cfg(input logic [5:0] v);
        stim_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_item(input logic [3:0] cmd, input logic [7:0] prio,
                                     input logic [31:0] handle);
        stim_row_t row;
        row                   = '{default: '0};
        row.word.command      = cmd;
        row.word.priority_req = prio;
        row.word.voice_handle = handle;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [3:0] cmd, input logic [7:0] prio,
                                        input logic [31:0] handle, input logic [1:0] st,
                                        input logic [31:0] gid, input logic [4:0] slot,
                                        input logic stolen, input logic [31:0] evicted,
                                        input logic [1:0] vstate, input logic [5:0] active);
        stim_row_t row;
        row                     = '{default: '0};
        row.word.command        = cmd;
        row.word.priority_req   = prio;
        row.word.voice_handle   = handle;
        row.has_exp             = 1'b1;
        row.exp.status          = st;
        row.exp.granted_id      = gid;
        row.exp.slot            = slot;
        row.exp.stolen          = stolen;
        row.exp.evicted_id      = evicted;
        row.exp.voice_state_out = vstate;
        row.exp.active_voices   = active;
        directed_rows.push_back(row);
    endfunction

    // one random command word, mostly aimed at live voices
    task automatic send_random;
        in_word_t w;
        int       pick;
        w    = '0;
        pick = $urandom_range(99);
        if (pick < 35)
            w.command = CMD_ACQUIRE;
        else if (pick < 45)
            w.command = CMD_STOP;
        else if (pick < 57)
            w.command = CMD_PAUSE;
        else if (pick < 69)
            w.command = CMD_RESUME;
        else if (pick < 81)
            w.command = CMD_QUERY;
        else if (pick < 84)
            w.command = CMD_STOP_ALL;
        else if (pick < 88)
            w.command = CMD_PAUSE_ALL;
        else if (pick < 92)
            w.command = CMD_RESUME_ALL;
        else if (pick < 98)
            w.command = CMD_SWEEP;
        else
            w.command = 4'($urandom_range(15, 9));
        // low priorities now and then so that full-pool refusals show up
        if ($urandom_range(3) == 0)
            w.priority_req = 8'($urandom_range(15));
        else
            w.priority_req = 8'($urandom_range(255));
        pick = $urandom_range(9);
        if (pick < 6)
            w.voice_handle = id_model[$urandom_range(POOL_SLOTS - 1)];
        else if (pick < 8)
            w.voice_handle = next_id_model - 32'($urandom_range(40)) - 32'd1;
        else if (pick == 8)
            w.voice_handle = 32'd0;
        else
            w.voice_handle = $urandom();
        send_word(w, 1'b0, '0);
    endtask

    // stimulus
    initial begin : stimulus
        int phase_en [PHASES];
        int phase_items [PHASES];
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        row_has_exp = 1'b0;
        row_exp     = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        errors      = 0;
        quiet_cycles = 0;
        n_items = 0; n_results = 0; n_steals = 0; n_full = 0; n_missed = 0; n_cfg = 0;

        // pool after reset
        for (int i = 0; i < POOL_SLOTS; i++) begin
            vs_model[i]   = VS_FREE;
            id_model[i]   = 32'd0;
            prio_model[i] = PRIO_RESET;
        end
        next_id_model = ID_FIRST;
        active_model  = 6'd0;
        en_model      = ENABLED_RESET;

        // lifecycle of two voices at the default pool size
        add_checked(CMD_QUERY, 8'd0, 32'd0, STATUS_NOT_FOUND, 0, 0, 0, 0, VS_FREE, 6'd0);
        add_checked(CMD_ACQUIRE, 8'd255, 32'd0, STATUS_OK, 1, 0, 0, 0, VS_PLAYING, 6'd1);
        add_checked(CMD_ACQUIRE, 8'd0, 32'd0, STATUS_OK, 2, 1, 0, 0, VS_PLAYING, 6'd2);
        add_checked(CMD_PAUSE, 8'd0, 32'd1, STATUS_OK, 1, 0, 0, 0, VS_PAUSED, 6'd2);
        // pause of a paused voice, resume of a playing one: no change
        add_checked(CMD_PAUSE, 8'd0, 32'd1, STATUS_OK, 1, 0, 0, 0, VS_PAUSED, 6'd2);
        add_checked(CMD_RESUME, 8'd0, 32'd2, STATUS_OK, 2, 1, 0, 0, VS_PLAYING, 6'd2);
        add_item(CMD_RESUME, 8'd0, 32'd1);
        add_checked(CMD_STOP, 8'd0, 32'd2, STATUS_OK, 2, 1, 0, 0, VS_FINISHED, 6'd2);
        add_item(CMD_QUERY, 8'd0, 32'd2);
        add_checked(CMD_QUERY, 8'd0, 32'hFFFF_FFFF, STATUS_NOT_FOUND, 0, 0, 0, 0, VS_FREE, 6'd2);
        add_checked(CMD_SWEEP, 8'd0, 32'd0, STATUS_OK, 0, 0, 0, 0, VS_FREE, 6'd1);
        add_checked(CMD_QUERY, 8'd0, 32'd2, STATUS_NOT_FOUND, 0, 0, 0, 0, VS_FREE, 6'd1);
        // undefined command with every priority and handle bit set
        add_checked(4'd15, 8'd255, 32'hFFFF_FFFF, STATUS_OK, 0, 0, 0, 0, VS_FREE, 6'd1);
        add_item(CMD_PAUSE_ALL, 8'd0, 32'd0);
        add_item(CMD_RESUME_ALL, 8'd0, 32'd0);
        add_item(CMD_STOP_ALL, 8'd0, 32'd0);
        add_checked(CMD_SWEEP, 8'd0, 32'd0, STATUS_OK, 0, 0, 0, 0, VS_FREE, 6'd0);
        // two-slot pool: fill, refuse, steal
        add_cfg(6'd2);
        add_checked(CMD_ACQUIRE, 8'd10, 32'd0, STATUS_OK, 3, 0, 0, 0, VS_PLAYING, 6'd1);
        add_item(CMD_ACQUIRE, 8'd20, 32'd0);
        add_checked(CMD_ACQUIRE, 8'd5, 32'd0, STATUS_FULL, 0, 0, 0, 0, VS_FREE, 6'd2);
        add_checked(CMD_ACQUIRE, 8'd10, 32'd0, STATUS_OK, 5, 0, 1, 3, VS_PLAYING, 6'd2);
        add_item(CMD_ACQUIRE, 8'd255, 32'd0);
        // no slot enabled
        add_cfg(6'd0);
        add_checked(CMD_ACQUIRE, 8'd255, 32'd0, STATUS_FULL, 0, 0, 0, 0, VS_FREE, 6'd2);
        add_checked(CMD_QUERY, 8'd0, 32'd6, STATUS_NOT_FOUND, 0, 0, 0, 0, VS_FREE, 6'd2);
        // count above the pool size clamps to the pool
        add_cfg(6'd63);
        add_item(CMD_QUERY, 8'd0, 32'd6);
        add_item(CMD_ACQUIRE, 8'd0, 32'd0);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg)
                write_enabled(directed_rows[k].cfg_val);
            else
                send_word(directed_rows[k].word, directed_rows[k].has_exp, directed_rows[k].exp);
        end

        // random phases: pool size and idling pattern change per phase
        phase_en    = '{4, 32, 1, 63, 0, 2, 8, 33, 0};
        phase_items = '{100, 100, 80, 100, 30, 90, 100, 60, 90};
        phase_en[PHASES - 1] = $urandom_range(40, 1);
        for (int p = 0; p < PHASES; p++) begin
            write_enabled(6'(phase_en[p]));
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            repeat (phase_items[p]) begin
                if ($urandom_range(99) == 0)
                    drain_results();
                send_random();
            end
        end

        drain_results();
        $display("ran %0d commands over %0d pool settings: %0d results checked,", n_items,
                 n_cfg, n_results);
        $display("%0d steals, %0d full-pool refusals, %0d missed lookups, %0d errors", n_steals,
                 n_full, n_missed, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
